>>> rtl/srpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_pkg: shared types and constants of the sensor record encoder
// Field widths, tag layout, varint digit size, the serializer phase type
// and the control/status bundles between sequencer and serializer.
// ----------------------------------------------------------------------------
package srpe_pkg;

	localparam int WORD_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int DIGIT_W   = 7;
	localparam int FLD_W     = 3;
	localparam int TAG_SHIFT = 3;
	localparam int QUEUE_D   = 5;

	localparam logic [FLD_W-1:0] FIELD_FIRST = 3'd1;
	localparam logic [FLD_W-1:0] SIGNED_LAST = 3'd4;
	localparam logic [FLD_W-1:0] FIELD_LAST  = 3'd6;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TAG,
		PH_DATA
	} srpe_phase_t;

	// sequencer to serializer
	typedef struct packed {
		logic              start;
		logic              adv;
		logic [FLD_W-1:0]  fld;
		logic [WORD_W-1:0] val;
	} srpe_vctl_t;

	// serializer to sequencer
	typedef struct packed {
		logic              active;
		logic              fld_end;
		logic [FLD_W-1:0]  fld;
		logic [BYTE_W-1:0] data;
	} srpe_vsts_t;

endpackage

>>> rtl/srpe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_rec_if / srpe_byte_if: valid/ready channels of the encoder
// Record channel carries the six sensor fields; byte channel carries the
// encoded stream with an end-of-record flag.
// ----------------------------------------------------------------------------
interface srpe_rec_if import srpe_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] temp_tenths;
	logic signed [WORD_W-1:0] accel_x;
	logic signed [WORD_W-1:0] accel_y;
	logic signed [WORD_W-1:0] accel_z;
	logic        [WORD_W-1:0] ambient_light;
	logic        [WORD_W-1:0] proximity;

	modport source (
		output valid, temp_tenths, accel_x, accel_y, accel_z, ambient_light, proximity,
		input  ready
	);
	modport sink (
		input  valid, temp_tenths, accel_x, accel_y, accel_z, ambient_light, proximity,
		output ready
	);
endinterface

interface srpe_byte_if import srpe_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;

	modport source (
		output valid, out_byte, last_byte,
		input  ready
	);
	modport sink (
		input  valid, out_byte, last_byte,
		output ready
	);
endinterface

>>> rtl/srpe_varint.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_varint: tag and base-128 varint serializer for one field
// Loads a field value (zigzag coding the signed fields), emits the tag byte,
// then shifts the value out seven bits per transfer, low digit first.
// ----------------------------------------------------------------------------
module srpe_varint import srpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  srpe_vctl_t ctl,
	output srpe_vsts_t sts
);

	srpe_phase_t       phase_q, phase_d;
	logic [WORD_W-1:0] val_q;
	logic [FLD_W-1:0]  fld_q;
	logic              more;
	logic              fld_end;
	logic [WORD_W-1:0] load_val;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// remaining digits beyond the current one
	assign more    = |val_q[WORD_W-1:DIGIT_W];
	assign fld_end = (phase_q == PH_DATA) && !more;

	// next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (ctl.start) begin
					phase_d = PH_TAG;
				end
			end
			PH_TAG: begin
				if (ctl.adv) begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (ctl.adv && !more) begin
					phase_d = ctl.start ? PH_TAG : PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// status follows the phase, the field register and the shift register only
	always_comb begin
		sts.active  = (phase_q == PH_TAG) || (phase_q == PH_DATA);
		sts.fld_end = fld_end;
		sts.fld     = fld_q;
		sts.data    = (phase_q == PH_TAG) ? (BYTE_W'(fld_q) << TAG_SHIFT)
			: {more, val_q[DIGIT_W-1:0]};
	end

	// zigzag the signed fields on load
	always_comb begin
		if (ctl.fld <= SIGNED_LAST) begin
			load_val = {ctl.val[WORD_W-2:0], 1'b0} ^ {WORD_W{ctl.val[WORD_W-1]}};
		end else begin
			load_val = ctl.val;
		end
	end

	// load a field, or drop one digit per data transfer
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			val_q <= load_val;
			fld_q <= ctl.fld;
		end else if (phase_q == PH_DATA && ctl.adv) begin
			val_q <= val_q >> DIGIT_W;
		end
	end

endmodule

>>> rtl/sensor_record_protobuf_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_record_protobuf_encoder: sensor record to protobuf byte stream
// Channel  | Dir | Payload
// rec      | in  | temp_tenths, accel_x, accel_y, accel_z (s32), ambient_light,
//          |     | proximity (u32)
// enc      | out | out_byte (8), last_byte (1, set on the final record byte)
//
// One record gives 12 to 36 output bytes. The record is taken first; then
// the varint serializer emits one byte per cycle unless enc stalls, and the
// next field loads as the previous field's last byte leaves. A new record is
// taken once the final byte has entered the output register. Stalls on enc
// hold the serializer. Reset clears the control state; the field queue and
// the output byte register are not reset.
// ----------------------------------------------------------------------------
module sensor_record_protobuf_encoder import srpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	srpe_rec_if.sink    rec,
	srpe_byte_if.source enc
);

	logic              busy_q;
	logic [WORD_W-1:0] fields_q [QUEUE_D];
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	srpe_vctl_t ctl;
	srpe_vsts_t sts;

	logic accept;
	logic adv;
	logic chain;
	logic rec_end;

	assign accept  = rec.valid && rec.ready;
	assign adv     = sts.active && (!out_valid_q || enc.ready);
	assign chain   = adv && sts.fld_end && (sts.fld != FIELD_LAST);
	assign rec_end = adv && sts.fld_end && (sts.fld == FIELD_LAST);

	// start the first field on accept, the next one as a field ends
	always_comb begin
		ctl.adv   = adv;
		ctl.start = accept || chain;
		if (accept) begin
			ctl.fld = FIELD_FIRST;
			ctl.val = rec.temp_tenths;
		end else begin
			ctl.fld = sts.fld + FLD_W'(1);
			ctl.val = fields_q[0];
		end
	end

	srpe_varint u_varint (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts)
	);

	// hold fields 2 to 6, advance one place as each later field starts
	always_ff @(posedge clk) begin
		if (accept) begin
			fields_q[0] <= rec.accel_x;
			fields_q[1] <= rec.accel_y;
			fields_q[2] <= rec.accel_z;
			fields_q[3] <= rec.ambient_light;
			fields_q[4] <= rec.proximity;
		end else if (chain) begin
			for (int i = 0; i < QUEUE_D - 1; i++) begin
				fields_q[i] <= fields_q[i+1];
			end
		end
	end

	// record in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (rec_end) begin
			busy_q <= 1'b0;
		end
	end

	assign rec.ready = !busy_q;

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (enc.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= sts.data;
			out_last_q <= rec_end;
		end
	end

	assign enc.valid     = out_valid_q;
	assign enc.out_byte  = out_byte_q;
	assign enc.last_byte = out_last_q;

endmodule

>>> sim/srpe_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_stream_checker: encoded byte stream checker for the sensor encoder
// Watches the record and byte channels, works out the protobuf encoding of
// every record transfer and compares each byte transfer, in order, with it.
// ----------------------------------------------------------------------------
module srpe_stream_checker import srpe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	srpe_rec_if   rec,
	srpe_byte_if  enc,
	output int    error_count,
	output int    bytes_pending
);

	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic              last;
	} enc_byte_t;

	enc_byte_t expected_bytes[$];

	initial begin
		error_count   = 0;
		bytes_pending = 0;
	end

	// Append one encoded byte to the expected stream
	function automatic void push_byte(input logic [BYTE_W-1:0] code, input logic last);
		enc_byte_t b;
		b.code = code;
		b.last = last;
		expected_bytes.push_back(b);
	endfunction

	// Encode six fields: tag, then zigzag (signed) or plain varint, low digit first
	function automatic void predict_encoding(input logic [5:0][WORD_W-1:0] words);
		logic [WORD_W-1:0] v;
		logic              rec_end;
		for (int fld = FIELD_FIRST; fld <= FIELD_LAST; fld++) begin
			v = words[fld - FIELD_FIRST];
			if (fld <= SIGNED_LAST) begin
				v = {v[WORD_W-2:0], 1'b0} ^ {WORD_W{v[WORD_W-1]}};
			end
			rec_end = (fld == FIELD_LAST);
			push_byte(BYTE_W'(fld) << TAG_SHIFT, 1'b0);
			while (v > 32'h7F) begin
				push_byte({1'b1, v[DIGIT_W-1:0]}, 1'b0);
				v = v >> DIGIT_W;
			end
			push_byte({1'b0, v[DIGIT_W-1:0]}, rec_end);
		end
	endfunction

	// Predict on record transfers, compare on byte transfers
	always @(posedge clk) begin
		enc_byte_t want;
		if (arst_n) begin
			if (rec.valid && rec.ready) begin
				predict_encoding({rec.proximity, rec.ambient_light, rec.accel_z,
					rec.accel_y, rec.accel_x, rec.temp_tenths});
			end
			if (enc.valid && enc.ready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected byte transfer: out_byte %02h last_byte %0b",
						enc.out_byte, enc.last_byte);
					error_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (enc.out_byte !== want.code) begin
						$error("out_byte: expected %02h, actual %02h", want.code, enc.out_byte);
						error_count++;
					end
					if (enc.last_byte !== want.last) begin
						$error("last_byte: expected %0b, actual %0b", want.last, enc.last_byte);
						error_count++;
					end
				end
			end
			bytes_pending <= expected_bytes.size();
		end
	end

endmodule

>>> sim/sensor_record_protobuf_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_record_protobuf_encoder_tb: stimulus and verdict for the encoder
// Sends directed boundary records, then random records of varied magnitude,
// with random idling on both channels, a long receiver hold-off and a full
// drain pause. A side checker predicts and compares the byte stream.
// ----------------------------------------------------------------------------
module sensor_record_protobuf_encoder_tb import srpe_pkg::*;;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_CYC   = 9;
	localparam int RAND_ITEMS  = 250;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT    = 37;

	logic clk;
	logic arst_n;
	int   error_count;
	int   bytes_pending;
	int   src_idle_pct  = IDLE_PCT;
	int   sink_idle_pct = IDLE_PCT;
	int   holds_asked   = 0;
	int   holds_done    = 0;

	srpe_rec_if  rec_ch ();
	srpe_byte_if enc_ch ();

	sensor_record_protobuf_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rec_ch),
		.enc    (enc_ch)
	);

	srpe_stream_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec           (rec_ch),
		.enc           (enc_ch),
		.error_count   (error_count),
		.bytes_pending (bytes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Random word with a random number of significant bits, optionally inverted
	function automatic logic [WORD_W-1:0] rand_word(input bit is_signed);
		logic [WORD_W-1:0] w;
		w = $urandom >> $urandom_range(WORD_W, 0);
		if (is_signed && $urandom_range(1, 0) == 1) begin
			w = ~w;
		end
		return w;
	endfunction

	// Offer one record after a random gap and hold it until the transfer
	task automatic send_record(
		input logic signed [WORD_W-1:0] temp,
		input logic signed [WORD_W-1:0] ax,
		input logic signed [WORD_W-1:0] ay,
		input logic signed [WORD_W-1:0] az,
		input logic        [WORD_W-1:0] light,
		input logic        [WORD_W-1:0] prox
	);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			rec_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rec_ch.valid         <= 1'b1;
		rec_ch.temp_tenths   <= temp;
		rec_ch.accel_x       <= ax;
		rec_ch.accel_y       <= ay;
		rec_ch.accel_z       <= az;
		rec_ch.ambient_light <= light;
		rec_ch.proximity     <= prox;
		do @(posedge clk); while (!rec_ch.ready);
	endtask

	// Hold until every expected byte has arrived
	task automatic wait_drained();
		do @(posedge clk); while (bytes_pending != 0);
	endtask

	// Receiver: random ready, plus long hold-offs on request
	initial begin
		int hold_left;
		hold_left = 0;
		enc_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				enc_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				enc_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
			end
		end
	end

	// Watchdog: end the run after too long without any transfer
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((rec_ch.valid && rec_ch.ready) || (enc_ch.valid && enc_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("sensor_record_protobuf_encoder_tb: done, errors");
		$finish;
	end

	// Sender: reset, directed records, random records, verdict
	initial begin
		arst_n               = 1'b0;
		rec_ch.valid         <= 1'b0;
		rec_ch.temp_tenths   <= '0;
		rec_ch.accel_x       <= '0;
		rec_ch.accel_y       <= '0;
		rec_ch.accel_z       <= '0;
		rec_ch.ambient_light <= '0;
		rec_ch.proximity     <= '0;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest record, then long fields mixed with small signed ones, then signed extremes
		send_record(0, 0, 0, 0, 0, 0);
		send_record(32'h7FFF_FFFF, 32'h8000_0000, -1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_record(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7F, 32'h80);
		// zigzag small values
		send_record(1, -1, 2, -2, 1, 0);
		// varint digit boundaries around one, two, three and four digits
		send_record(63, -64, 64, -65, 32'h3FFF, 32'h4000);
		send_record(8191, -8192, 8192, -8193, 32'h1F_FFFF, 32'h20_0000);
		send_record(1048575, -1048576, 1048576, -1048577, 32'h0FFF_FFFF, 32'h1000_0000);
		send_record(32'h07FF_FFFF, 32'hF800_0000, 32'h0800_0000, -1,
			32'h0FFF_FFFF, 32'h1000_0000);
		// toggling bit patterns
		send_record(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC,
			32'h5555_5555, 32'hAAAA_AAAA);
		send_record(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333,
			32'hAAAA_AAAA, 32'h5555_5555);
		rec_ch.valid <= 1'b0;
		wait_drained();

		// random records with back-pressure phases along the way
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 40) begin
				holds_asked++;
			end
			if (i == 110) begin
				rec_ch.valid <= 1'b0;
				wait_drained();
			end
			if (i == 150) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			if (i == 200) begin
				src_idle_pct  = IDLE_PCT;
				sink_idle_pct = IDLE_PCT;
			end
			send_record(rand_word(1'b1), rand_word(1'b1), rand_word(1'b1), rand_word(1'b1),
				rand_word(1'b0), rand_word(1'b0));
		end
		rec_ch.valid <= 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && bytes_pending == 0) begin
			$display("sensor_record_protobuf_encoder_tb: done, clean");
		end else begin
			$display("sensor_record_protobuf_encoder_tb: done, errors");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/srpe_pkg.sv
rtl/srpe_if.sv
rtl/srpe_varint.sv
rtl/sensor_record_protobuf_encoder.sv
sim/srpe_stream_checker.sv
sim/sensor_record_protobuf_encoder_tb.sv
